// ===== design/imerge_pkg.sv =====
package imerge_pkg;

    localparam int MAX_INTERVALS = 16;
    localparam int COORD_WIDTH   = 32;
    localparam int FIELD_W       = 32;

    typedef struct packed {
        logic                          valid;
        logic signed [COORD_WIDTH-1:0] lo;
        logic signed [COORD_WIDTH-1:0] hi;
    } t_span;

    typedef struct packed {
        logic insert;   // new interval enters the chain this cycle
        logic shift;    // chain moves one cell toward the head
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_FILL  = 2'b01,
        S_DRAIN = 2'b10
    } t_state;

    function automatic logic [FIELD_W-1:0] zext(input logic [COORD_WIDTH-1:0] v);
        logic [FIELD_W-1:0] r;
        r = '0;
        r[COORD_WIDTH-1:0] = v;
        return r;
    endfunction

endpackage

// ===== design/imerge_cell.sv =====
module imerge_cell
    import imerge_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_span     i_new,
    input  t_span     i_prev,
    input  logic      i_prev_take,
    input  t_span     i_next,
    output t_span     o_cell,
    output logic      o_take
);

    t_span r_cell;
    t_span n_cell;

    // Strict compare keeps equal starts in arrival order.
    assign o_take = !r_cell.valid || (r_cell.lo > i_new.lo);
    assign o_cell = r_cell;

    always_comb begin
        n_cell = r_cell;
        if (i_ctl.shift) begin
            n_cell = i_next;
        end else if (i_ctl.insert && o_take) begin
            n_cell = i_prev_take ? i_prev : i_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else begin
            r_cell.valid <= n_cell.valid;
        end
        r_cell.lo <= n_cell.lo;
        r_cell.hi <= n_cell.hi;
    end

endmodule

// ===== design/imerge_run.sv =====
module imerge_run
    import imerge_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_active,
    input  t_span                i_head,
    input  logic                 i_dropped,
    output logic                 o_advance,
    output logic                 o_done,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [2*FIELD_W-1:0] m_axis_tdata,
    output logic                 m_axis_tlast,
    output logic                 m_axis_tuser
);

    t_span               r_run;
    logic                r_out_valid;
    logic [2*FIELD_W-1:0] r_out_data;
    logic                r_out_last;
    logic                r_out_ovf;

    t_span               n_run;
    logic                n_out_valid;
    logic                emit;
    logic                emit_last;
    logic                out_free;

    assign out_free  = !r_out_valid || m_axis_tready;
    assign o_advance = i_active && out_free;
    assign o_done    = o_advance && !i_head.valid;

    always_comb begin
        n_run     = r_run;
        emit      = 1'b0;
        emit_last = 1'b0;
        if (o_advance) begin
            if (!i_head.valid) begin
                emit      = 1'b1;
                emit_last = 1'b1;
                n_run.valid = 1'b0;
            end else if (!r_run.valid) begin
                n_run = i_head;
            end else if (i_head.lo <= r_run.hi) begin
                if (i_head.hi > r_run.hi) begin
                    n_run.hi = i_head.hi;
                end
            end else begin
                emit  = 1'b1;
                n_run = i_head;
            end
        end
        n_out_valid = emit ? 1'b1 : (r_out_valid && !m_axis_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run.valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_run.valid <= n_run.valid;
            r_out_valid <= n_out_valid;
        end
        r_run.lo <= n_run.lo;
        r_run.hi <= n_run.hi;
        if (emit) begin
            r_out_data <= {zext(r_run.hi), zext(r_run.lo)};
            r_out_last <= emit_last;
            r_out_ovf  <= i_dropped;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_ovf;

endmodule

// ===== design/interval_merge_engine.sv =====
// Interval merge engine.
// Slave stream: one closed interval per transaction; tdata carries start in
// [31:0] and end in [63:32], tlast marks the final interval of a set.
// Intervals are inserted into a chain of MAX_INTERVALS cells kept ordered by
// start (equal starts keep arrival order); the slave side takes one interval
// per cycle while a set is being loaded. Intervals arriving when the chain is
// full are dropped and the set's overflow flag is raised.
// After the transaction with tlast, s_axis_tready drops and the chain shifts
// toward its head into a merge unit, one cell per cycle while the output
// register can take a result. Each merged interval leaves through a single
// output register as one master transaction (tdata = start [31:0], end
// [63:32]; tlast on the final one of the set; tuser = overflow). A stalled
// receiver freezes the drain: the chain and the running interval hold until
// the output register frees up.
// The slave side opens again in the cycle after the final result is loaded.
// Reset (synchronous, active low) empties the chain, clears the overflow flag
// and discards any pending result.
module interval_merge_engine
    import imerge_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [2*FIELD_W-1:0] s_axis_tdata,  // interval_start, interval_end
    input  logic                 s_axis_tlast,  // set_last
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [2*FIELD_W-1:0] m_axis_tdata,  // merged_start, merged_end
    output logic                 m_axis_tlast,  // run_last
    output logic                 m_axis_tuser   // overflow
);

    t_state    r_state;
    t_state    n_state;
    logic      r_dropped;
    logic      n_dropped;

    t_span     new_span;
    t_cell_ctl ctl;
    t_span     cells [MAX_INTERVALS];
    logic      takes [MAX_INTERVALS];
    logic      accept;
    logic      full;
    logic      advance;
    logic      done;

    assign s_axis_tready = (r_state == S_FILL);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign full          = cells[MAX_INTERVALS-1].valid;

    // Only the low COORD_WIDTH bits of each coordinate count.
    assign new_span.valid = 1'b1;
    assign new_span.lo    = s_axis_tdata[COORD_WIDTH-1:0];
    assign new_span.hi    = s_axis_tdata[FIELD_W+COORD_WIDTH-1:FIELD_W];

    assign ctl.insert = accept && !full;
    assign ctl.shift  = advance;

    // Ordered cell chain: insert broadcasts the new interval, shift drains
    // toward cell 0.
    for (genvar g = 0; g < MAX_INTERVALS; g++) begin : g_cell
        t_span prev_cell;
        logic  prev_take;
        t_span next_cell;
        if (g == 0) begin : g_head
            assign prev_cell = new_span;
            assign prev_take = 1'b0;
        end else begin : g_body
            assign prev_cell = cells[g-1];
            assign prev_take = takes[g-1];
        end
        if (g == MAX_INTERVALS - 1) begin : g_tail
            assign next_cell = '0;
        end else begin : g_inner
            assign next_cell = cells[g+1];
        end
        imerge_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl),
            .i_new       (new_span),
            .i_prev      (prev_cell),
            .i_prev_take (prev_take),
            .i_next      (next_cell),
            .o_cell      (cells[g]),
            .o_take      (takes[g])
        );
    end

    imerge_run u_run (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_active      (r_state == S_DRAIN),
        .i_head        (cells[0]),
        .i_dropped     (r_dropped),
        .o_advance     (advance),
        .o_done        (done),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always_comb begin
        n_state   = r_state;
        n_dropped = r_dropped;
        case (r_state)
            S_FILL: begin
                // drop the interval when the chain is full, remember it
                if (accept && full) begin
                    n_dropped = 1'b1;
                end
                if (accept && s_axis_tlast) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (done) begin
                    n_state   = S_FILL;
                    n_dropped = 1'b0;
                end
            end
            default: begin
                n_state   = S_FILL;
                n_dropped = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_FILL;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_dropped <= n_dropped;
        end
    end

endmodule
